// ===== rtl/core/mmcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcd_pkg
// Shared types, register map and reset values of the min/max column
// decimator.
// ----------------------------------------------------------------------------
package mmcd_pkg;

  // Sample code width and fixed register widths
  localparam int SAMPLE_BITS = 8;
  localparam int COUNT_BITS  = 9;
  localparam int STEP_BITS   = 32;
  localparam int SCALE_BITS  = 21;
  localparam int INDEX_BITS  = 16;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_COLUMNS  = 512;
  localparam int DEF_TRACE_HEIGHT = 17;

  // APB register map
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int REG_BITS  = 3;

  localparam logic [REG_BITS-1:0] REG_COLUMN_COUNT   = 3'd0;
  localparam logic [REG_BITS-1:0] REG_COLUMN_STEP    = 3'd1;
  localparam logic [REG_BITS-1:0] REG_LOW_CODE       = 3'd2;
  localparam logic [REG_BITS-1:0] REG_HIGH_CODE      = 3'd3;
  localparam logic [REG_BITS-1:0] REG_NONE_CODE      = 3'd4;
  localparam logic [REG_BITS-1:0] REG_ORDINATE_SCALE = 3'd5;

  // Register reset values
  localparam logic [COUNT_BITS-1:0]  RST_COLUMN_COUNT   = 9'd282;
  localparam logic [STEP_BITS-1:0]   RST_COLUMN_STEP    = 32'd7456540;
  localparam logic [SAMPLE_BITS-1:0] RST_LOW_CODE       = 8'd2;
  localparam logic [SAMPLE_BITS-1:0] RST_HIGH_CODE      = 8'd254;
  localparam logic [SAMPLE_BITS-1:0] RST_NONE_CODE      = 8'd0;
  localparam logic [SCALE_BITS-1:0]  RST_ORDINATE_SCALE = 21'd4420;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [COUNT_BITS-1:0]  column_count;
    logic [STEP_BITS-1:0]   column_step;
    logic [SAMPLE_BITS-1:0] low_code;
    logic [SAMPLE_BITS-1:0] high_code;
    logic [SAMPLE_BITS-1:0] none_code;
    logic [SCALE_BITS-1:0]  ordinate_scale;
  } cfg_t;

endpackage

// ===== rtl/core/minmax_column_decimator.sv =====
// ----------------------------------------------------------------------------
// minmax_column_decimator
// Reduces a frame of samples to one min/max span per display column and
// maps each widened bound to a pixel ordinate.
// ----------------------------------------------------------------------------
//  Channel   Handshake                      Payload
//  -------   ---------                      -------
//  sample    sample_valid / sample_ready    sample, frame_start
//  column    column_valid / column_ready    column, upper_y, lower_y,
//                                           upper_valid, lower_valid, last
//  config    APB psel/penable/pwrite        paddr, pwdata, prdata
//
// One sample is taken every cycle while the result register is free or
// being emptied. After the sample that closes a column, its result is held first in
// the tracker's event register, then in the result register behind the ordinate mapping.
// Both stages advance together, so a stalled result holds back new samples.
// Reset is synchronous and acts as a frame start; no clearing pass is needed.
// ----------------------------------------------------------------------------
module minmax_column_decimator #(
  parameter int MAX_COLUMNS  = mmcd_pkg::DEF_MAX_COLUMNS,
  parameter int TRACE_HEIGHT = mmcd_pkg::DEF_TRACE_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmcd_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [mmcd_pkg::DATA_BITS-1:0]    pwdata,
  output logic [mmcd_pkg::DATA_BITS-1:0]    prdata,
  output logic                              pready,
  // samples
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic [mmcd_pkg::SAMPLE_BITS-1:0]  sample,
  input  logic                              frame_start,
  // column results
  output logic                              column_valid,
  input  logic                              column_ready,
  output logic [$clog2(MAX_COLUMNS)-1:0]    column,
  output logic [$clog2(TRACE_HEIGHT+1)-1:0] upper_y,
  output logic [$clog2(TRACE_HEIGHT+1)-1:0] lower_y,
  output logic                              upper_valid,
  output logic                              lower_valid,
  output logic                              last
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int YW = $clog2(TRACE_HEIGHT+1);
  localparam int SB = mmcd_pkg::SAMPLE_BITS;

  mmcd_pkg::cfg_t cfg;

  logic          advance;
  logic          accept;
  logic          ev_valid;
  logic [CW-1:0] ev_column;
  logic [SB-1:0] ev_wmax;
  logic [SB-1:0] ev_wmin;
  logic          ev_last;
  logic [YW-1:0] up_y, lo_y;
  logic          up_ok, lo_ok;

  // Advance the pipeline when the result register is free or drained
  assign advance      = !column_valid || column_ready;
  assign sample_ready = advance;
  assign accept       = sample_valid && sample_ready;

  mmcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mmcd_tracker #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (advance),
    .accept      (accept),
    .sample      (sample),
    .frame_start (frame_start),
    .ev_valid    (ev_valid),
    .ev_column   (ev_column),
    .ev_wmax     (ev_wmax),
    .ev_wmin     (ev_wmin),
    .ev_last     (ev_last)
  );

  mmcd_ordinate #(
    .TRACE_HEIGHT (TRACE_HEIGHT)
  ) u_upper (
    .code (ev_wmax),
    .cfg  (cfg),
    .y    (up_y),
    .ok   (up_ok)
  );

  mmcd_ordinate #(
    .TRACE_HEIGHT (TRACE_HEIGHT)
  ) u_lower (
    .code (ev_wmin),
    .cfg  (cfg),
    .y    (lo_y),
    .ok   (lo_ok)
  );

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      column_valid <= 1'b0;
    end else if (advance) begin
      column_valid <= ev_valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance && ev_valid) begin
      column      <= ev_column;
      upper_y     <= up_y;
      lower_y     <= lo_y;
      upper_valid <= up_ok;
      lower_valid <= lo_ok;
      last        <= ev_last;
    end
  end

  // An empty result register always takes a request
  assert property (@(posedge clk) disable iff (rst) !column_valid |-> sample_ready)
    else $error("sample_ready low with empty result register");

  // Ordinates stay within the trace
  assert property (@(posedge clk) disable iff (rst)
    column_valid |-> (32'(upper_y) <= TRACE_HEIGHT) && (32'(lower_y) <= TRACE_HEIGHT))
    else $error("ordinate beyond trace height");

  // An absent bound carries a zero ordinate
  assert property (@(posedge clk) disable iff (rst)
    column_valid |-> (upper_valid || upper_y == '0) && (lower_valid || lower_y == '0))
    else $error("absent bound with non-zero ordinate");

  // A stalled result stays put with its payload unchanged
  assert property (@(posedge clk) disable iff (rst)
    column_valid && !column_ready |=> column_valid &&
      $stable({column, upper_y, lower_y, upper_valid, lower_valid, last}))
    else $error("stalled result lost or changed");

endmodule

// ===== rtl/core/mmcd_regs.sv =====
// ----------------------------------------------------------------------------
// mmcd_regs
// APB configuration registers; writes complete in the access phase, reads
// return the stored value.
// ----------------------------------------------------------------------------
module mmcd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mmcd_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [mmcd_pkg::DATA_BITS-1:0]  pwdata,
  output logic [mmcd_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  output mmcd_pkg::cfg_t                  cfg
);

  logic                          wr_en;
  logic [mmcd_pkg::REG_BITS-1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[mmcd_pkg::ADDR_BITS-1:2];

  // Store the written register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_count   <= mmcd_pkg::RST_COLUMN_COUNT;
      cfg.column_step    <= mmcd_pkg::RST_COLUMN_STEP;
      cfg.low_code       <= mmcd_pkg::RST_LOW_CODE;
      cfg.high_code      <= mmcd_pkg::RST_HIGH_CODE;
      cfg.none_code      <= mmcd_pkg::RST_NONE_CODE;
      cfg.ordinate_scale <= mmcd_pkg::RST_ORDINATE_SCALE;
    end else if (wr_en) begin
      unique case (reg_sel)
        mmcd_pkg::REG_COLUMN_COUNT:
          cfg.column_count <= pwdata[mmcd_pkg::COUNT_BITS-1:0];
        mmcd_pkg::REG_COLUMN_STEP:
          cfg.column_step <= pwdata[mmcd_pkg::STEP_BITS-1:0];
        mmcd_pkg::REG_LOW_CODE:
          cfg.low_code <= pwdata[mmcd_pkg::SAMPLE_BITS-1:0];
        mmcd_pkg::REG_HIGH_CODE:
          cfg.high_code <= pwdata[mmcd_pkg::SAMPLE_BITS-1:0];
        mmcd_pkg::REG_NONE_CODE:
          cfg.none_code <= pwdata[mmcd_pkg::SAMPLE_BITS-1:0];
        mmcd_pkg::REG_ORDINATE_SCALE:
          cfg.ordinate_scale <= pwdata[mmcd_pkg::SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (reg_sel)
      mmcd_pkg::REG_COLUMN_COUNT:   prdata = mmcd_pkg::DATA_BITS'(cfg.column_count);
      mmcd_pkg::REG_COLUMN_STEP:    prdata = mmcd_pkg::DATA_BITS'(cfg.column_step);
      mmcd_pkg::REG_LOW_CODE:       prdata = mmcd_pkg::DATA_BITS'(cfg.low_code);
      mmcd_pkg::REG_HIGH_CODE:      prdata = mmcd_pkg::DATA_BITS'(cfg.high_code);
      mmcd_pkg::REG_NONE_CODE:      prdata = mmcd_pkg::DATA_BITS'(cfg.none_code);
      mmcd_pkg::REG_ORDINATE_SCALE: prdata = mmcd_pkg::DATA_BITS'(cfg.ordinate_scale);
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/mmcd_tracker.sv =====
// ----------------------------------------------------------------------------
// mmcd_tracker
// Column tracker: follows the sample position against the column starts,
// keeps the running min/max, widens the span on column close and holds the
// closed column in an event register.
// ----------------------------------------------------------------------------
module mmcd_tracker #(
  parameter int MAX_COLUMNS = mmcd_pkg::DEF_MAX_COLUMNS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mmcd_pkg::cfg_t                    cfg,
  input  logic                              advance,
  input  logic                              accept,
  input  logic [mmcd_pkg::SAMPLE_BITS-1:0]  sample,
  input  logic                              frame_start,
  output logic                              ev_valid,
  output logic [$clog2(MAX_COLUMNS)-1:0]    ev_column,
  output logic [mmcd_pkg::SAMPLE_BITS-1:0]  ev_wmax,
  output logic [mmcd_pkg::SAMPLE_BITS-1:0]  ev_wmin,
  output logic                              ev_last
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int SB = mmcd_pkg::SAMPLE_BITS;
  localparam int IB = mmcd_pkg::INDEX_BITS;
  localparam int AB = mmcd_pkg::STEP_BITS;

  // State registers
  logic [IB-1:0] sample_index, sample_index_next;
  logic [CW-1:0] column_index, column_index_next;
  logic [AB-1:0] start_acc, start_acc_next;
  logic [SB-1:0] running_min, running_min_next;
  logic [SB-1:0] running_max, running_max_next;
  logic [SB-1:0] previous_min, previous_min_next;
  logic [SB-1:0] previous_max, previous_max_next;
  logic          frame_done, frame_done_next;
  logic          col_open, col_open_next;

  // Frame-start view of the state
  logic [IB-1:0] si;
  logic [CW-1:0] ci;
  logic [AB-1:0] acc;
  logic          open_e;
  logic          done_e;

  logic [IB-1:0] start_pos;
  logic [IB-1:0] col_len;
  logic [IB:0]   col_end;
  logic [AB:0]   acc_sum;
  logic [SB-1:0] nmin, nmax;
  logic          skip;
  logic          close;
  logic          is_last;
  logic [SB-1:0] wmax, wmin;

  assign si     = frame_start ? '0 : sample_index;
  assign ci     = frame_start ? '0 : column_index;
  assign acc    = frame_start ? '0 : start_acc;
  assign open_e = frame_start ? 1'b0 : col_open;
  assign done_e = frame_start ? 1'b0 : frame_done;

  // Column bounds: start = floor(acc), length = max(1, floor(step))
  assign start_pos = acc[AB-1:IB];
  assign col_len   = (cfg.column_step[AB-1:IB] == '0) ? IB'(1) : cfg.column_step[AB-1:IB];
  assign col_end   = {1'b0, start_pos} + {1'b0, col_len} - (IB+1)'(1);
  assign acc_sum   = {1'b0, acc} + {1'b0, cfg.column_step};

  assign skip = done_e || (cfg.column_count == '0) || (si == '1);

  // Fold the new sample into the running bounds
  always_comb begin
    if (!open_e) begin
      nmin = sample;
      nmax = sample;
    end else begin
      nmin = (sample < running_min) ? sample : running_min;
      nmax = (sample > running_max) ? sample : running_max;
    end
  end

  // Widen toward the previous column's raw span
  always_comb begin
    wmax = nmax;
    wmin = nmin;
    if (ci != '0) begin
      if (nmax < previous_min) wmax = previous_min;
      if (nmin > previous_max) wmin = previous_max;
    end
  end

  assign is_last = (32'(ci) == (32'(cfg.column_count) - 32'd1));

  // Next state for an accepted request
  always_comb begin
    sample_index_next = sample_index;
    column_index_next = column_index;
    start_acc_next    = start_acc;
    running_min_next  = running_min;
    running_max_next  = running_max;
    previous_min_next = previous_min;
    previous_max_next = previous_max;
    frame_done_next   = frame_done;
    col_open_next     = col_open;
    close             = 1'b0;
    if (accept) begin
      sample_index_next = si;
      column_index_next = ci;
      start_acc_next    = acc;
      col_open_next     = open_e;
      frame_done_next   = done_e;
      if (!skip) begin
        sample_index_next = si + IB'(1);
        if (open_e || (si >= start_pos)) begin
          col_open_next    = 1'b1;
          running_min_next = nmin;
          running_max_next = nmax;
          if ({1'b0, si} >= col_end) begin
            close             = 1'b1;
            previous_min_next = nmin;
            previous_max_next = nmax;
            column_index_next = ci + CW'(1);
            start_acc_next    = acc_sum[AB] ? '1 : acc_sum[AB-1:0];
            col_open_next     = 1'b0;
            if (is_last) frame_done_next = 1'b1;
          end
        end
      end
    end
  end

  // Hold state and the closed-column event
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      column_index <= '0;
      start_acc    <= '0;
      running_min  <= '0;
      running_max  <= '0;
      previous_min <= '0;
      previous_max <= '0;
      frame_done   <= 1'b0;
      col_open     <= 1'b0;
      ev_valid     <= 1'b0;
    end else begin
      sample_index <= sample_index_next;
      column_index <= column_index_next;
      start_acc    <= start_acc_next;
      running_min  <= running_min_next;
      running_max  <= running_max_next;
      previous_min <= previous_min_next;
      previous_max <= previous_max_next;
      frame_done   <= frame_done_next;
      col_open     <= col_open_next;
      if (advance) ev_valid <= close;
    end
  end

  // Event payload
  always_ff @(posedge clk) begin
    if (advance && close) begin
      ev_column <= ci;
      ev_wmax   <= wmax;
      ev_wmin   <= wmin;
      ev_last   <= is_last;
    end
  end

endmodule

// ===== rtl/core/mmcd_ordinate.sv =====
// ----------------------------------------------------------------------------
// mmcd_ordinate
// Maps one bound code to a pixel ordinate: clamp to the code span, scale by
// the Q5.16 factor, subtract from the trace height plus one half to round.
// ----------------------------------------------------------------------------
module mmcd_ordinate #(
  parameter int TRACE_HEIGHT = mmcd_pkg::DEF_TRACE_HEIGHT
) (
  input  logic [mmcd_pkg::SAMPLE_BITS-1:0]  code,
  input  mmcd_pkg::cfg_t                    cfg,
  output logic [$clog2(TRACE_HEIGHT+1)-1:0] y,
  output logic                              ok
);

  localparam int SB = mmcd_pkg::SAMPLE_BITS;
  localparam int YW = $clog2(TRACE_HEIGHT+1);
  localparam int PW = mmcd_pkg::SCALE_BITS + SB;
  localparam int VW = (PW > 24) ? PW + 1 : 25;
  localparam logic [VW-1:0] BASE = VW'(TRACE_HEIGHT * 65536 + 32768);

  logic [SB-1:0] span;
  logic [SB-1:0] d_raw;
  logic [SB-1:0] d;
  logic [PW-1:0] scale_x;
  logic [PW-1:0] d_x;
  logic [PW-1:0] prod;
  logic [VW-1:0] diff;

  // Clamp the offset from the bottom code into the span
  assign span  = (cfg.high_code > cfg.low_code) ? (cfg.high_code - cfg.low_code) : '0;
  assign d_raw = (code > cfg.low_code) ? (code - cfg.low_code) : '0;
  assign d     = (d_raw > span) ? span : d_raw;

  // Scale and round
  assign scale_x = PW'(cfg.ordinate_scale);
  assign d_x     = PW'(d);
  assign prod    = scale_x * d_x;
  assign diff    = BASE - VW'(prod);

  assign ok = (code != cfg.none_code);
  assign y  = (!ok || (VW'(prod) > BASE)) ? '0 : diff[16 +: YW];

endmodule
